### design/mbrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR parser package
// Shared types and constants for the partition table parser.
// ----------------------------------------------------------------------------
package mbrp_pkg;

  // Sector layout
  localparam logic [8:0] TableBase  = 9'h1be;
  localparam logic [8:0] TableEnd   = 9'h1fe;  // first position past the table
  localparam logic [8:0] SigHiPos   = 9'd510;
  localparam logic [8:0] SigLoPos   = 9'd511;
  localparam logic [7:0] SigHiByte  = 8'h55;
  localparam logic [7:0] SigLoByte  = 8'haa;
  localparam int unsigned TableEntries = 4;
  localparam int unsigned EntryAddrW   = 2;

  // Entry field values
  localparam logic [7:0] BootActive  = 8'h80;
  localparam logic [7:0] BootNone    = 8'h00;
  localparam logic [7:0] TypeEmpty   = 8'h00;
  localparam logic [7:0] TypeExtChs  = 8'h05;
  localparam logic [7:0] TypeExtLba  = 8'h0f;
  localparam logic [7:0] TypeExtLnx  = 8'h85;
  localparam logic [7:0] TypeGptProt = 8'hee;

  localparam logic [15:0] GoodBlockSize = 16'd512;

  // Result status codes
  localparam logic [1:0] StEntry  = 2'd0;
  localparam logic [1:0] StBadSec = 2'd1;
  localparam logic [1:0] StNoSlot = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CfgBlockSize   = 2'd0;
  localparam logic [1:0] CfgTotalBlocks = 2'd1;
  localparam logic [1:0] CfgCapacity    = 2'd2;

  // One stored table entry
  typedef struct packed {
    logic [7:0]  boot;
    logic [7:0]  ptype;
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // End-of-sector notice from capture to emitter
  typedef struct packed {
    logic valid;
    logic sig_ok;
  } sector_done_t;

endpackage

### design/mbr_partition_table_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition table parser
// Parses the primary partition table and signature of a disk's first sector.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the 512 bytes of sector 0 in address order on sector_byte_i with
//   in_valid_i / in_ready_o; one request is taken per cycle. Table entries
//   are assembled in a staging register and written whole into a 4-entry RAM
//   as their last byte arrives. On byte 511 the block queues its results:
//   one error result (bad block size or signature), one no-slot result
//   (capacity zero), or min(capacity, ENTRY_SLOTS) entry results, the last
//   one flagged by last_o.
//   Output: a result is queued, read from the entry RAM (entry results)
//   and checked into the output register; further results follow one per
//   cycle while out_ready_i is high.
//   Throughput: one byte per cycle. If results of a sector are still being
//   read back from the entry RAM when the next sector reaches its table
//   bytes, in_ready_o drops until the last RAM read has issued; an output
//   stall therefore only holds the sender once it reaches the table.
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and
//   cfg_data_i; always ready, unknown indexes are dropped. Write only while
//   the block is idle.
//   Reset: byte position clears to zero, no results pending, config returns
//   to block size 512, total blocks 0, capacity 4.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser
  import mbrp_pkg::*;
#(
  parameter int unsigned ENTRY_SLOTS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sector bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  sector_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  entry_index_o,
  output logic [31:0] start_block_o,
  output logic [31:0] block_count_o,
  output logic        bootable_o,
  output logic        last_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [15:0] block_size_q;
  logic [63:0] total_blocks_q;
  logic [2:0]  capacity_q;

  logic                  busy;
  logic                  we;
  logic [EntryAddrW-1:0] waddr;
  entry_t                wdata;
  logic                  re;
  logic [EntryAddrW-1:0] raddr;
  entry_t                rdata;
  sector_done_t          done;

  // Config registers: always accept, drop writes to unknown indexes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q   <= GoodBlockSize;
      total_blocks_q <= '0;
      capacity_q     <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBlockSize:   block_size_q   <= cfg_data_i[15:0];
        CfgTotalBlocks: total_blocks_q <= cfg_data_i;
        CfgCapacity:    capacity_q     <= cfg_data_i[2:0];
        default:        ;
      endcase
    end
  end

  // Byte position tracking and entry assembly
  mbrp_capture u_capture (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .sector_byte_i,
    .busy_i  (busy),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .done_o  (done)
  );

  // Entry store
  mbrp_ram #(
    .Width (EntryW),
    .Depth (TableEntries)
  ) u_entry_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read back, check and present results
  mbrp_emit #(
    .EntrySlots (ENTRY_SLOTS)
  ) u_emit (
    .clk_i,
    .rst_ni,
    .done_i         (done),
    .block_size_i   (block_size_q),
    .total_blocks_i (total_blocks_q),
    .capacity_i     (capacity_q),
    .busy_o         (busy),
    .re_o           (re),
    .raddr_o        (raddr),
    .rdata_i        (rdata),
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .entry_index_o,
    .start_block_o,
    .block_count_o,
    .bootable_o,
    .last_o
  );

endmodule

### design/mbrp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data held while idle.
// ----------------------------------------------------------------------------
module mbrp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mbrp_capture.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR byte capture
// Tracks the byte position, assembles table entries and writes them to RAM.
// ----------------------------------------------------------------------------
module mbrp_capture
  import mbrp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            sector_byte_i,
  input  logic                  busy_i,
  output logic                  we_o,
  output logic [EntryAddrW-1:0] waddr_o,
  output entry_t                wdata_o,
  output sector_done_t          done_o
);

  logic [8:0]  pos_q, pos_d;
  logic [8:0]  off;
  logic [3:0]  w;
  logic        in_table;
  logic        accept;
  logic [7:0]  boot_q, type_q, sig_hi_q;
  logic [31:0] start_q;
  logic [23:0] len_q;

  assign in_table = (pos_q >= TableBase) && (pos_q < TableEnd);
  assign off      = pos_q - TableBase;
  assign w        = off[3:0];

  // Stall over the table while the previous sector's entries are still read
  assign in_ready_o = !(busy_i && in_table);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_d      = pos_q + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_table) begin
      case (w)
        4'd0:    boot_q <= sector_byte_i;
        4'd4:    type_q <= sector_byte_i;
        4'd8:    start_q[7:0]   <= sector_byte_i;
        4'd9:    start_q[15:8]  <= sector_byte_i;
        4'd10:   start_q[23:16] <= sector_byte_i;
        4'd11:   start_q[31:24] <= sector_byte_i;
        4'd12:   len_q[7:0]     <= sector_byte_i;
        4'd13:   len_q[15:8]    <= sector_byte_i;
        4'd14:   len_q[23:16]   <= sector_byte_i;
        default: ;
      endcase
    end
    if (accept && (pos_q == SigHiPos)) begin
      sig_hi_q <= sector_byte_i;
    end
  end

  // Write the whole entry on its last byte
  assign we_o           = accept && in_table && (w == 4'd15);
  assign waddr_o        = off[5:4];
  assign wdata_o.boot   = boot_q;
  assign wdata_o.ptype  = type_q;
  assign wdata_o.start  = start_q;
  assign wdata_o.length = {sector_byte_i, len_q};

  assign done_o.valid  = accept && (pos_q == SigLoPos);
  assign done_o.sig_ok = (sig_hi_q == SigHiByte) && (sector_byte_i == SigLoByte);

endmodule

### design/mbrp_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR result emitter
// Reads stored entries back, checks them and drives the result register.
// ----------------------------------------------------------------------------
module mbrp_emit
  import mbrp_pkg::*;
#(
  parameter int unsigned EntrySlots = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sector_done_t          done_i,
  input  logic [15:0]           block_size_i,
  input  logic [63:0]           total_blocks_i,
  input  logic [2:0]            capacity_i,
  output logic                  busy_o,
  output logic                  re_o,
  output logic [EntryAddrW-1:0] raddr_o,
  input  entry_t                rdata_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            status_o,
  output logic [1:0]            entry_index_o,
  output logic [31:0]           start_block_o,
  output logic [31:0]           block_count_o,
  output logic                  bootable_o,
  output logic                  last_o
);

  localparam logic [2:0] SlotsW = 3'(EntrySlots);

  logic       special_q, special_d;
  logic [1:0] spec_st_q, spec_st_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       rd_valid_q, rd_valid_d;
  logic [1:0] rd_st_q, rd_st_d;
  logic [1:0] rd_idx_q, rd_idx_d;
  logic       rd_last_q, rd_last_d;
  logic       out_valid_q, out_valid_d;
  logic       load_out;
  logic       advance, can_issue;
  logic [2:0] n;
  logic       boot_ok, type_ok, fits, ok;
  logic [32:0] end_blk;

  assign n = (capacity_i < SlotsW) ? capacity_i : SlotsW;

  assign advance   = !out_valid_q || out_ready_i;
  assign can_issue = !rd_valid_q || advance;
  assign busy_o    = special_q || (cnt_q != 3'd0);

  always_comb begin
    special_d  = special_q;
    spec_st_d  = spec_st_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    rd_valid_d = rd_valid_q;
    rd_st_d    = rd_st_q;
    rd_idx_d   = rd_idx_q;
    rd_last_d  = rd_last_q;
    re_o       = 1'b0;
    raddr_o    = idx_q;

    // Start a sector's results; capture stalls so we are idle here
    if (done_i.valid) begin
      if ((block_size_i != GoodBlockSize) || !done_i.sig_ok) begin
        special_d = 1'b1;
        spec_st_d = StBadSec;
      end else if (n == 3'd0) begin
        special_d = 1'b1;
        spec_st_d = StNoSlot;
      end else begin
        cnt_d = n;
        idx_d = '0;
      end
    end

    if (can_issue) begin
      if (special_q) begin
        rd_valid_d = 1'b1;
        rd_st_d    = spec_st_q;
        rd_idx_d   = '0;
        rd_last_d  = 1'b1;
        special_d  = 1'b0;
      end else if (cnt_q != 3'd0) begin
        re_o       = 1'b1;
        rd_valid_d = 1'b1;
        rd_st_d    = StEntry;
        rd_idx_d   = idx_q;
        rd_last_d  = (cnt_q == 3'd1);
        cnt_d      = cnt_q - 3'd1;
        idx_d      = idx_q + 2'd1;
      end else begin
        rd_valid_d = 1'b0;
      end
    end
  end

  // Entry checks
  assign boot_ok = (rdata_i.boot == BootNone) || (rdata_i.boot == BootActive);
  assign type_ok = !((rdata_i.ptype == TypeEmpty) || (rdata_i.ptype == TypeExtChs) ||
                     (rdata_i.ptype == TypeExtLba) || (rdata_i.ptype == TypeExtLnx) ||
                     (rdata_i.ptype == TypeGptProt));
  assign end_blk = {1'b0, rdata_i.start} + {1'b0, rdata_i.length};
  assign fits    = {31'd0, end_blk} <= total_blocks_i;
  assign ok      = boot_ok && type_ok && (rdata_i.length != 32'd0) && fits;

  assign load_out    = rd_valid_q && advance;
  assign out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_q   <= 1'b0;
      spec_st_q   <= StEntry;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      rd_st_q     <= StEntry;
      rd_idx_q    <= '0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      special_q   <= special_d;
      spec_st_q   <= spec_st_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_valid_d;
      rd_st_q     <= rd_st_d;
      rd_idx_q    <= rd_idx_d;
      rd_last_q   <= rd_last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      status_o <= rd_st_q;
      last_o   <= rd_last_q;
      if (rd_st_q == StEntry) begin
        entry_index_o <= rd_idx_q;
        start_block_o <= rdata_i.start;
        block_count_o <= ok ? rdata_i.length : 32'd0;
        bootable_o    <= ok && (rdata_i.boot == BootActive);
      end else begin
        entry_index_o <= '0;
        start_block_o <= '0;
        block_count_o <= '0;
        bootable_o    <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### dv/mbr_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR table result checker
// Watches the sector, result and register-write channels of the partition
// table parser. It keeps its own copy of the captured table, the signature
// and the register values, predicts the results of each sector on its last
// byte, and compares every accepted result field by field.
// ----------------------------------------------------------------------------
module mbr_table_checker
  import mbrp_pkg::*;
#(
  parameter int unsigned EntrySlots = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  sector_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [1:0]  entry_index_i,
  input  logic [31:0] start_block_i,
  input  logic [31:0] block_count_i,
  input  logic        bootable_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        drain_i,
  output int          mismatches_o,
  output int          sectors_closed_o,
  output int          results_checked_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  index;
    logic [31:0] start;
    logic [31:0] count;
    logic        boot;
    logic        last;
  } table_result_t;

  localparam int unsigned PrintLimit = 50;

  logic [15:0]   blk_size_q;
  logic [63:0]   total_q;
  logic [2:0]    slots_q;
  logic [8:0]    pos_q;
  entry_t        table_q [TableEntries];
  logic [15:0]   sig_q;
  table_result_t results_due [$];

  initial begin
    mismatches_o      = 0;
    sectors_closed_o  = 0;
    results_checked_o = 0;
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    if (mismatches_o < PrintLimit) begin
      $display("[%0t] MISMATCH %s: got 'h%0h, want 'h%0h", $time, what, got, want);
    end
    mismatches_o++;
  endtask

  function automatic logic entry_usable(entry_t e);
    logic [63:0] span_end;
    span_end = 64'(e.start) + 64'(e.length);
    if (e.boot != BootNone && e.boot != BootActive) return 1'b0;
    if (e.ptype == TypeEmpty || e.ptype == TypeExtChs || e.ptype == TypeExtLba ||
        e.ptype == TypeExtLnx || e.ptype == TypeGptProt) return 1'b0;
    return (e.length != 32'd0) && (span_end <= total_q);
  endfunction

  // Queue the results of the sector whose last byte was just taken.
  task automatic close_sector();
    int unsigned   n;
    logic          ok;
    table_result_t r;
    n = (slots_q > EntrySlots) ? EntrySlots : slots_q;
    r = '0;
    r.last = 1'b1;
    if (blk_size_q != GoodBlockSize || sig_q != {SigHiByte, SigLoByte}) begin
      r.status = StBadSec;
      results_due.push_back(r);
    end else if (n == 0) begin
      r.status = StNoSlot;
      results_due.push_back(r);
    end else begin
      for (int i = 0; i < n; i++) begin
        ok       = entry_usable(table_q[i]);
        r.status = StEntry;
        r.index  = 2'(i);
        r.start  = table_q[i].start;
        r.count  = ok ? table_q[i].length : 32'd0;
        r.boot   = ok && (table_q[i].boot == BootActive);
        r.last   = (i == n - 1);
        results_due.push_back(r);
      end
    end
  endtask

  task automatic take_byte(logic [7:0] b);
    logic [8:0] off;
    if (pos_q >= TableBase && pos_q < TableEnd) begin
      off = pos_q - TableBase;
      case (off[3:0])
        4'd0:                      table_q[off[5:4]].boot = b;
        4'd4:                      table_q[off[5:4]].ptype = b;
        4'd8, 4'd9, 4'd10, 4'd11:  table_q[off[5:4]].start[8*off[1:0] +: 8] = b;
        4'd12, 4'd13, 4'd14, 4'd15: table_q[off[5:4]].length[8*off[1:0] +: 8] = b;
        default: ;
      endcase
    end else if (pos_q == SigHiPos) begin
      sig_q[15:8] = b;
    end else if (pos_q == SigLoPos) begin
      sig_q[7:0] = b;
    end
    if (pos_q == SigLoPos) close_sector();
    pos_q = pos_q + 9'd1;
  endtask

  task automatic check_result();
    table_result_t want;
    if (results_due.size() == 0) begin
      report("result with none due, status", status_i, 0);
    end else begin
      want = results_due.pop_front();
      if (status_i !== want.status)      report("status", status_i, want.status);
      if (entry_index_i !== want.index)  report("entry_index", entry_index_i, want.index);
      if (start_block_i !== want.start)  report("start_block", start_block_i, want.start);
      if (block_count_i !== want.count)  report("block_count", block_count_i, want.count);
      if (bootable_i !== want.boot)      report("bootable", bootable_i, want.boot);
      if (last_i !== want.last)          report("last", last_i, want.last);
      results_checked_o <= results_checked_o + 1;
      if (want.last) sectors_closed_o <= sectors_closed_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_size_q = GoodBlockSize;
      total_q    = '0;
      slots_q    = 3'd4;
      pos_q      = '0;
      sig_q      = '0;
      foreach (table_q[k]) table_q[k] = '0;
      results_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgBlockSize:   blk_size_q = cfg_data_i[15:0];
          CfgTotalBlocks: total_q    = cfg_data_i;
          CfgCapacity:    slots_q    = cfg_data_i[2:0];
          default: ;
        endcase
      end
      // check before taking a byte, so a result can never meet its own sector
      if (out_valid_i && out_ready_i) check_result();
      if (in_valid_i && in_ready_i) take_byte(sector_byte_i);
    end
  end

  always @(posedge drain_i) begin
    if (results_due.size() != 0) begin
      report("results never delivered, count", results_due.size(), 0);
    end
  end

endmodule

### dv/mbr_partition_table_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MBR partition table parser testbench
// Streams whole 512-byte sectors into the parser: a directed set for the
// register extremes, every rejected entry kind, bad block size, bad
// signature and zero capacity, then random sectors under three handshake
// mixes. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser_tb
  import mbrp_pkg::*;
;

  localparam int unsigned Slots        = 4;
  localparam int unsigned SectorBytes  = 512;
  localparam int unsigned IdleLimit    = 10000;  // cycles without any request
  localparam int unsigned LongHold     = 1500;   // receiver hold-off, in cycles
  localparam int unsigned DrainCycles  = 6;      // parser latency plus margin
  localparam logic [1:0]  CfgNoReg     = 2'd3;   // no register at this index
  localparam logic [7:0]  TypeLinux    = 8'h83;
  localparam logic [7:0]  TypeFat32    = 8'h0c;
  localparam logic [7:0]  BootBogus    = 8'h81;
  localparam logic [7:0]  BootAllOnes  = 8'hff;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  sector_byte_i = '0;
  logic        out_ready_i   = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [1:0]  cfg_index_i   = CfgBlockSize;
  logic [63:0] cfg_data_i    = '0;
  logic        drain_check   = 1'b0;

  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [1:0]  entry_index_o;
  logic [31:0] start_block_o;
  logic [31:0] block_count_o;
  logic        bootable_o;
  logic        last_o;
  logic        cfg_ready_o;

  int mismatches;
  int sectors_closed;
  int results_checked;

  int          sectors_sent  = 0;
  int          cfg_writes    = 0;
  int          tx_idle_pct   = 0;
  int          rx_idle_pct   = 0;
  int          hold_requests = 0;
  int          holds_done    = 0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;
  logic [63:0] cur_total     = '0;  // what total_blocks holds, for entry shaping

  mbr_partition_table_parser #(
    .ENTRY_SLOTS   (Slots)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sector_byte_i (sector_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .entry_index_o (entry_index_o),
    .start_block_o (start_block_o),
    .block_count_o (block_count_o),
    .bootable_o    (bootable_o),
    .last_o        (last_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  mbr_table_checker #(
    .EntrySlots        (Slots)
  ) i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .sector_byte_i     (sector_byte_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .entry_index_i     (entry_index_o),
    .start_block_i     (start_block_o),
    .block_count_i     (block_count_o),
    .bootable_i        (bootable_o),
    .last_i            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .drain_i           (drain_check),
    .mismatches_o      (mismatches),
    .sectors_closed_o  (sectors_closed),
    .results_checked_o (results_checked)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random back-pressure, plus a long hold-off on request from
  // the stimulus. The hold is counted here so the sender keeps running
  // meanwhile and the parser has to stall its sector input.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done  <= holds_done + 1;
      hold_left   <= LongHold;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: end the run if no request moves on any channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog: no request moved for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sector byte; idle first at the current sender rate. Valid is
  // left high after the request so back-to-back bytes need no second write.
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sector_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Lay out a sector: table fields where the parser looks, the two signature
  // bytes at the end, random filler everywhere else (CHS bytes included).
  task automatic send_sector(entry_t tbl [TableEntries], logic [7:0] sig_hi,
                             logic [7:0] sig_lo);
    int unsigned off;
    logic [7:0]  b;
    for (int p = 0; p < SectorBytes; p++) begin
      b = 8'($urandom);
      if (p >= TableBase && p < TableEnd) begin
        off = p - TableBase;
        case (off % 16)
          0:              b = tbl[off / 16].boot;
          4:              b = tbl[off / 16].ptype;
          8, 9, 10, 11:   b = tbl[off / 16].start[8 * (off % 4) +: 8];
          12, 13, 14, 15: b = tbl[off / 16].length[8 * (off % 4) +: 8];
          default: ;
        endcase
      end else if (p == SigHiPos) begin
        b = sig_hi;
      end else if (p == SigLoPos) begin
        b = sig_lo;
      end
      send_byte(b);
    end
    sectors_sent++;
  endtask

  // Drop valid, wait for the last result of every sector sent, then give
  // the parser its latency before anything touches the registers.
  task automatic settle();
    in_valid_i <= 1'b0;
    wait (sectors_closed == sectors_sent);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_writes++;
  endtask

  // Write all three registers; junk in the unused upper bits must be dropped.
  task automatic configure(logic [15:0] bsize, logic [63:0] total, logic [2:0] cap);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    cfg_write(CfgBlockSize, {junk[63:16], bsize});
    cfg_write(CfgTotalBlocks, total);
    junk = {$urandom, $urandom};
    cfg_write(CfgCapacity, {junk[63:3], cap});
    if ($urandom_range(3) == 0) cfg_write(CfgNoReg, {$urandom, $urandom});
    cfg_valid_i <= 1'b0;
    cur_total = total;
  endtask

  task automatic rand_configure();
    logic [15:0] bsize;
    logic [63:0] total;
    logic [2:0]  cap;
    int          r;
    bsize = ($urandom_range(99) < 85) ? GoodBlockSize : 16'($urandom);
    cap   = ($urandom_range(3) == 0) ? 3'd4 : 3'($urandom_range(7));
    r = $urandom_range(9);
    if (r < 4)       total = 64'($urandom_range(4096, 1));
    else if (r < 7)  total = {32'd0, $urandom};
    else if (r == 7) total = '0;
    else if (r == 8) total = 64'h1_0000_0000;
    else             total = $urandom_range(1) ? '1 : {$urandom, $urandom};
    configure(bsize, total, cap);
  endtask

  // Random entry, shaped against the disk size so that fits, exact ends,
  // one-past-the-end and zero lengths all come up often.
  function automatic entry_t rand_entry();
    entry_t      e;
    logic [31:0] lim;
    int          r;
    lim = (cur_total > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff : cur_total[31:0];
    if ($urandom_range(99) < 75) e.boot = $urandom_range(1) ? BootActive : BootNone;
    else                         e.boot = 8'($urandom);
    r = $urandom_range(99);
    if (r < 60)      e.ptype = 8'($urandom);
    else if (r < 68) e.ptype = TypeEmpty;
    else if (r < 76) e.ptype = TypeExtChs;
    else if (r < 84) e.ptype = TypeExtLba;
    else if (r < 92) e.ptype = TypeExtLnx;
    else             e.ptype = TypeGptProt;
    e.start = $urandom_range(lim);
    case ($urandom_range(4))
      0: e.length = '0;
      1: e.length = $urandom_range(lim - e.start);
      2: e.length = lim - e.start;
      3: e.length = lim - e.start + 32'd1;
      default: begin
        e.start  = $urandom;
        e.length = $urandom;
      end
    endcase
    return e;
  endfunction

  // Mostly well-formed sectors; the rest carry a broken signature or are
  // pure noise.
  task automatic rand_sector();
    entry_t     tbl [TableEntries];
    logic [7:0] hi;
    logic [7:0] lo;
    int         kind;
    kind = $urandom_range(99);
    hi   = SigHiByte;
    lo   = SigLoByte;
    foreach (tbl[k]) begin
      if (kind < 90) tbl[k] = rand_entry();
      else           tbl[k] = {16'($urandom), $urandom, $urandom};
    end
    if (kind >= 78 && kind < 90) begin
      if ($urandom_range(1)) hi = hi ^ 8'($urandom_range(255, 1));
      else                   lo = lo ^ 8'($urandom_range(255, 1));
    end else if (kind >= 90) begin
      hi = 8'($urandom);
      lo = 8'($urandom);
    end
    send_sector(tbl, hi, lo);
  endtask

  initial begin
    entry_t tbl [TableEntries];

    // first mix: sender idles now and then, receiver mostly stalls
    tx_idle_pct = 30;
    rx_idle_pct <= 85;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Registers at reset: 512-byte blocks, empty disk, four slots, so every
    // entry is rejected and reports a zero count.
    tbl = '{{BootActive, TypeLinux, 32'd0, 32'd1},
            {BootNone, TypeLinux, 32'd0, 32'd0},
            {BootNone, TypeEmpty, 32'd0, 32'd0},
            {BootActive, TypeFat32, 32'hffff_ffff, 32'hffff_ffff}};
    send_sector(tbl, SigHiByte, SigLoByte);

    // Largest disk, capacity above the slot count: saturate to four results.
    settle();
    configure(GoodBlockSize, '1, 3'd7);
    tbl = '{{BootActive, TypeLinux, 32'hffff_ffff, 32'hffff_ffff},
            {BootNone, TypeFat32, 32'd0, 32'd1},
            {BootBogus, TypeLinux, 32'd5, 32'd5},
            {BootActive, TypeGptProt, 32'd1, 32'd1}};
    send_sector(tbl, SigHiByte, SigLoByte);
    // the extended types, and a bad flag with zero length
    tbl = '{{BootNone, TypeExtChs, 32'd1, 32'd1},
            {BootNone, TypeExtLba, 32'd1, 32'd1},
            {BootActive, TypeExtLnx, 32'd1, 32'd1},
            {BootAllOnes, TypeLinux, 32'd2, 32'd0}};
    send_sector(tbl, SigHiByte, SigLoByte);

    // Disk of exactly 2^32 blocks: an end on the boundary fits, one past
    // does not, and the sum needs its carry bit.
    settle();
    configure(GoodBlockSize, 64'h1_0000_0000, 3'd3);
    tbl = '{{BootActive, TypeLinux, 32'hffff_ffff, 32'd1},
            {BootNone, TypeLinux, 32'hffff_ffff, 32'd2},
            {BootNone, TypeLinux, 32'd0, 32'hffff_ffff},
            {BootActive, TypeLinux, 32'd0, 32'd1}};
    send_sector(tbl, SigHiByte, SigLoByte);

    // One slot, then each signature byte broken on its own.
    settle();
    configure(GoodBlockSize, 64'd1000, 3'd1);
    tbl[0] = {BootActive, TypeLinux, 32'd999, 32'd1};
    send_sector(tbl, SigHiByte, SigLoByte);
    send_sector(tbl, SigHiByte ^ 8'h01, SigLoByte);
    send_sector(tbl, SigHiByte, SigLoByte ^ 8'h80);

    // Bad block size wins over zero capacity; the stray index must not land.
    settle();
    cfg_write(CfgNoReg, '1);
    configure(16'd513, 64'd1000, 3'd0);
    send_sector(tbl, SigHiByte, SigLoByte);

    // Zero capacity: no-slot result on a good sector, error on a bad one.
    settle();
    configure(GoodBlockSize, 64'd1000, 3'd0);
    send_sector(tbl, SigHiByte, SigLoByte);
    send_sector(tbl, SigHiByte, 8'h00);

    // block size extremes, then two slots with a good sector
    settle();
    configure(16'd0, 64'd1000, 3'd2);
    send_sector(tbl, SigHiByte, SigLoByte);
    settle();
    configure(16'hffff, 64'd0, 3'd2);
    send_sector(tbl, SigHiByte, SigLoByte);
    settle();
    configure(GoodBlockSize, 64'd1000, 3'd2);
    send_sector(tbl, SigHiByte, SigLoByte);

    // Random part: three mixes, four register settings each, four random
    // sectors per setting. Each change first drains every pending result.
    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          tx_idle_pct = 30;
          rx_idle_pct <= 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct <= 30;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (int grp = 0; grp < 4; grp++) begin
        settle();
        if (mix == 2 && grp == 0) begin
          // With a free-running sender, hold results long enough that the
          // next sector reaches its table and the parser stalls its input.
          // A good sector with four slots keeps the entry reads pending.
          configure(GoodBlockSize, '1, 3'd4);
          hold_requests <= hold_requests + 1;
          send_sector(tbl, SigHiByte, SigLoByte);
        end else begin
          rand_configure();
        end
        repeat (4) rand_sector();
      end
    end

    settle();
    drain_check <= 1'b1;
    @(posedge clk_i);

    $display("covered %0d sectors, %0d results compared, %0d register writes",
             sectors_sent, results_checked, cfg_writes);
    $display("mixes: sender-light/receiver-heavy, reversed, no idling, one long stall");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
